// ===== hdl/frwa_pkg.sv =====
// Shared types and codes for the FIFO-fair readers/writer lock arbiter.
// Used by frwa_queue, frwa_ctrl and the top level; depends on nothing.
`default_nettype none

package frwa_pkg;

    localparam int CMD_W     = 2;
    localparam int REQ_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int READERS_W = 5;
    localparam int ENTRY_W   = REQ_W + 1;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int REQUESTERS_DEF  = 16;

    localparam logic [CMD_W-1:0] CMD_ENTER_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXIT_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ENTER_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EXIT_WRITE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_GRANT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd4;

    localparam logic [READERS_W-1:0] READERS_MAX = 5'd31;
    localparam logic [READERS_W-1:0] GRANTS_MAX  = 5'd16;

    // Queue operation requested by the sequencer
    typedef struct packed {
        logic             push;
        logic             pop;
        logic             kind;
        logic [REQ_W-1:0] who;
    } frwa_qop_t;

    // Queue status seen by the sequencer
    typedef struct packed {
        logic             empty;
        logic             full;
        logic             single;
        logic             head_kind;
        logic [REQ_W-1:0] head_who;
        logic             next_kind;
    } frwa_qstat_t;

endpackage

`default_nettype wire

// ===== hdl/frwa_queue.sv =====
// Wait queue of the arbiter: circular memory with head, tail and fill count.
// Reads the head entry and the one behind it into registers. Uses frwa_pkg.
`default_nettype none

module frwa_queue #(
    parameter int QUEUE_DEPTH = frwa_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire frwa_pkg::frwa_qop_t  qop,
    output frwa_pkg::frwa_qstat_t     qstat
);
    import frwa_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

    logic [PW-1:0]      head_reg, head_next;
    logic [PW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [ENTRY_W-1:0] rd_head_reg;
    logic [ENTRY_W-1:0] rd_next_reg;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (qop.push)
        begin
            tail_next  = wrap_inc(tail_reg);
            count_next = count_reg + CW'(1);
        end
        else if (qop.pop)
        begin
            head_next  = wrap_inc(head_reg);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Read ahead at the next head so a pop shows the new head in the next cycle
    always_ff @(posedge clk)
    begin
        if (qop.push)
            mem[tail_reg] <= {qop.kind, qop.who};
        rd_head_reg <= mem[head_next];
        rd_next_reg <= mem[wrap_inc(head_next)];
    end

    assign qstat.empty     = (count_reg == '0);
    assign qstat.full      = (count_reg == FULL_CNT);
    assign qstat.single    = (count_reg == CW'(1));
    assign qstat.head_kind = rd_head_reg[REQ_W];
    assign qstat.head_who  = rd_head_reg[REQ_W-1:0];
    assign qstat.next_kind = rd_next_reg[REQ_W];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        qop.push |-> !qstat.full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        qop.pop |-> (!qstat.empty && !qop.push))
        else $error("pop from empty queue or with push");
`endif

endmodule

`default_nettype wire

// ===== hdl/frwa_ctrl.sv =====
// Sequencer of the arbiter: lock state, event decode, head drain and the
// result register. Drives frwa_queue through frwa_qop_t. Uses frwa_pkg.
`default_nettype none

module frwa_ctrl #(
    parameter int REQUESTERS = frwa_pkg::REQUESTERS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [frwa_pkg::CMD_W-1:0]       command,
    input  wire  [frwa_pkg::REQ_W-1:0]       requester,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [frwa_pkg::STATUS_W-1:0]    status,
    output logic [frwa_pkg::REQ_W-1:0]       grant_requester,
    output logic                             grant_kind,
    output logic                             last,
    output frwa_pkg::frwa_qop_t              qop,
    input  wire frwa_pkg::frwa_qstat_t       qstat
);
    import frwa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_WAKE = 2'd2;

    localparam logic [8:0] REQ_LIMIT = 9'(REQUESTERS);

    logic [1:0]           state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [REQ_W-1:0]     who_reg, who_next;
    logic                 writer_reg, writer_next;
    logic [READERS_W-1:0] readers_reg, readers_next;
    logic [READERS_W-1:0] gcnt_reg, gcnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [REQ_W-1:0]     grq_reg, grq_next;
    logic                 gkind_reg, gkind_next;
    logic                 last_reg, last_next;

    logic                 out_free;
    logic                 emit;
    logic                 out_of_range;
    logic                 ev_kind;

    assign out_free     = !out_valid_reg || !out_stall;
    assign out_of_range = ({5'b0, who_reg} >= REQ_LIMIT);
    assign ev_kind      = cmd_reg[1];

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        who_next     = who_reg;
        writer_next  = writer_reg;
        readers_next = readers_reg;
        gcnt_next    = gcnt_reg;
        emit         = 1'b0;
        status_next  = status_reg;
        grq_next     = who_reg;
        gkind_next   = ev_kind;
        last_next    = 1'b1;
        qop.push     = 1'b0;
        qop.pop      = 1'b0;
        qop.kind     = ev_kind;
        qop.who      = who_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    who_next   = requester;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (out_of_range)
                    begin
                        emit        = 1'b1;
                        status_next = ST_ERROR;
                    end
                    else
                    begin
                        case (cmd_reg)
                            CMD_ENTER_READ:
                            begin
                                emit = 1'b1;
                                if (!writer_reg && qstat.empty)
                                begin
                                    if (readers_reg == READERS_MAX)
                                        status_next = ST_ERROR;
                                    else
                                    begin
                                        readers_next = readers_reg + READERS_W'(1);
                                        status_next  = ST_GRANT;
                                    end
                                end
                                else if (qstat.full)
                                    status_next = ST_FULL;
                                else
                                begin
                                    qop.push    = 1'b1;
                                    status_next = ST_QUEUED;
                                end
                            end
                            CMD_EXIT_READ:
                            begin
                                if (readers_reg == '0)
                                begin
                                    emit        = 1'b1;
                                    status_next = ST_ERROR;
                                end
                                else
                                begin
                                    readers_next = readers_reg - READERS_W'(1);
                                    if (readers_reg == READERS_W'(1) && !qstat.empty)
                                    begin
                                        gcnt_next  = '0;
                                        state_next = S_WAKE;
                                    end
                                    else
                                    begin
                                        emit        = 1'b1;
                                        status_next = ST_RELEASED;
                                    end
                                end
                            end
                            CMD_ENTER_WRITE:
                            begin
                                emit = 1'b1;
                                if (!writer_reg && readers_reg == '0)
                                begin
                                    writer_next = 1'b1;
                                    status_next = ST_GRANT;
                                end
                                else if (qstat.full)
                                    status_next = ST_FULL;
                                else
                                begin
                                    qop.push    = 1'b1;
                                    status_next = ST_QUEUED;
                                end
                            end
                            CMD_EXIT_WRITE:
                            begin
                                if (!writer_reg)
                                begin
                                    emit        = 1'b1;
                                    status_next = ST_ERROR;
                                end
                                else
                                begin
                                    writer_next = 1'b0;
                                    if (!qstat.empty)
                                    begin
                                        gcnt_next  = '0;
                                        state_next = S_WAKE;
                                    end
                                    else
                                    begin
                                        emit        = 1'b1;
                                        status_next = ST_RELEASED;
                                    end
                                end
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_WAKE:
            begin
                // Grant one head entry per cycle while the output is free; peek behind it to flag the final word
                if (out_free)
                begin
                    emit        = 1'b1;
                    qop.pop     = 1'b1;
                    status_next = ST_GRANT;
                    grq_next    = qstat.head_who;
                    if (gcnt_reg == '0 && qstat.head_kind)
                    begin
                        writer_next = 1'b1;
                        gkind_next  = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        readers_next = readers_reg + READERS_W'(1);
                        gcnt_next    = gcnt_reg + READERS_W'(1);
                        gkind_next   = 1'b0;
                        last_next    = qstat.single
                                    || (gcnt_reg == GRANTS_MAX - READERS_W'(1))
                                    || (readers_reg == READERS_MAX - READERS_W'(1))
                                    || qstat.next_kind;
                        if (last_next)
                            state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            writer_reg    <= 1'b0;
            readers_reg   <= '0;
            gcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            writer_reg    <= writer_next;
            readers_reg   <= readers_next;
            gcnt_reg      <= gcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        who_reg <= who_next;
        if (emit)
        begin
            status_reg <= status_next;
            grq_reg    <= grq_next;
            gkind_reg  <= gkind_next;
            last_reg   <= last_next;
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign grant_requester = grq_reg;
    assign grant_kind      = gkind_reg;
    assign last            = last_reg;

`ifndef SYNTHESIS
    a_writer_excl: assert property (@(posedge clk) disable iff (!rst_n)
        writer_reg |-> (readers_reg == '0))
        else $error("writer active with readers");
    a_wake_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAKE) |-> !qstat.empty)
        else $error("drain with empty queue");
    a_grant_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gcnt_reg <= GRANTS_MAX)
        else $error("drain grant count beyond limit");
`endif

endmodule

`default_nettype wire

// ===== hdl/fifo_fair_readers_writers_arbiter_unit.sv =====
// Top level of the FIFO-fair readers/writer lock arbiter.
// Instantiates frwa_ctrl and frwa_queue; uses frwa_pkg.
//
//   port group  dir  handshake               payload
//   in          in   in_valid / in_stall     command, requester
//   out         out  out_valid / out_stall   status, grant_requester, grant_kind, last
//
// An event is accepted in S_IDLE and decoded in S_EVAL; each grant drained from the
// wait queue (one writer, or up to 16 readers) then follows in S_WAKE, one queue head
// read per cycle while the output is not stalled. in_stall stays high until the
// final word of an event has been placed in the output register. out_stall holds
// the output register and pauses the sequencer. Reset clears lock state and queue
// pointers.
`default_nettype none

module fifo_fair_readers_writers_arbiter_unit #(
    parameter int QUEUE_DEPTH = frwa_pkg::QUEUE_DEPTH_DEF,
    parameter int REQUESTERS  = frwa_pkg::REQUESTERS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [frwa_pkg::CMD_W-1:0]       command,
    input  wire  [frwa_pkg::REQ_W-1:0]       requester,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [frwa_pkg::STATUS_W-1:0]    status,
    output logic [frwa_pkg::REQ_W-1:0]       grant_requester,
    output logic                             grant_kind,
    output logic                             last
);
    import frwa_pkg::*;

    frwa_qop_t   qop;
    frwa_qstat_t qstat;

    frwa_ctrl #(
        .REQUESTERS (REQUESTERS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .requester       (requester),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .grant_requester (grant_requester),
        .grant_kind      (grant_kind),
        .last            (last),
        .qop             (qop),
        .qstat           (qstat)
    );

    frwa_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .qop   (qop),
        .qstat (qstat)
    );

endmodule

`default_nettype wire

// ===== tb/frwa_lock_checker.sv =====
// Watches both channels of the readers/writer lock arbiter, predicts every result word
// and compares it with what the block delivers. Depends on frwa_pkg only.
`timescale 1ns / 1ps

module frwa_lock_checker #(
    parameter int QUEUE_DEPTH = frwa_pkg::QUEUE_DEPTH_DEF,
    parameter int REQUESTERS  = frwa_pkg::REQUESTERS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    input  wire                           in_stall,
    input  wire [frwa_pkg::CMD_W-1:0]     command,
    input  wire [frwa_pkg::REQ_W-1:0]     requester,
    input  wire                           out_valid,
    input  wire                           out_stall,
    input  wire [frwa_pkg::STATUS_W-1:0]  status,
    input  wire [frwa_pkg::REQ_W-1:0]     grant_requester,
    input  wire                           grant_kind,
    input  wire                           last,
    output int                            failures,
    output int                            outstanding
);
    import frwa_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REQ_W-1:0]    who;
        logic                kind;
        logic                last;
    } lock_word_t;

    // Shadow of the lock state
    logic                 writer_busy;
    logic [READERS_W-1:0] reader_count;
    logic                 wait_kind [QUEUE_DEPTH];
    logic [REQ_W-1:0]     wait_who [QUEUE_DEPTH];
    int                   wait_head;
    int                   wait_tail;
    int                   wait_count;

    lock_word_t expected_words[$];
    lock_word_t seen_word;
    lock_word_t want_word;

    task automatic add_word(input logic [STATUS_W-1:0] st, input logic [REQ_W-1:0] who,
                            input logic kind);
        lock_word_t w;
        w.status = st;
        w.who    = who;
        w.kind   = kind;
        w.last   = 1'b0;
        expected_words.push_back(w);
    endtask

    task automatic drop_head();
        wait_head  = (wait_head + 1) % QUEUE_DEPTH;
        wait_count = wait_count - 1;
    endtask

    task automatic park_request(input logic [REQ_W-1:0] who, input logic kind);
        if (wait_count >= QUEUE_DEPTH)
        begin
            add_word(ST_FULL, who, kind);
        end
        else
        begin
            wait_kind[wait_tail] = kind;
            wait_who[wait_tail]  = who;
            wait_tail  = (wait_tail + 1) % QUEUE_DEPTH;
            wait_count = wait_count + 1;
            add_word(ST_QUEUED, who, kind);
        end
    endtask

    // Grant the head: one writer, or a run of readers capped by count and grant limit
    task automatic wake_waiters(output int grants);
        grants = 0;
        if (wait_count != 0 && wait_kind[wait_head])
        begin
            writer_busy = 1'b1;
            add_word(ST_GRANT, wait_who[wait_head], 1'b1);
            drop_head();
            grants = 1;
        end
        else
        begin
            while (wait_count != 0 && grants < int'(GRANTS_MAX) &&
                   reader_count < READERS_MAX && !wait_kind[wait_head])
            begin
                reader_count = reader_count + 1'b1;
                add_word(ST_GRANT, wait_who[wait_head], 1'b0);
                drop_head();
                grants = grants + 1;
            end
        end
    endtask

    task automatic predict_lock_event(input logic [CMD_W-1:0] cmd, input logic [REQ_W-1:0] who);
        int         grants;
        lock_word_t w;
        grants = 0;
        if (int'(who) >= REQUESTERS)
        begin
            add_word(ST_ERROR, who, cmd[1]);
        end
        else
        begin
            case (cmd)
                CMD_ENTER_READ:
                begin
                    if (!writer_busy && wait_count == 0)
                    begin
                        if (reader_count >= READERS_MAX)
                        begin
                            add_word(ST_ERROR, who, 1'b0);
                        end
                        else
                        begin
                            reader_count = reader_count + 1'b1;
                            add_word(ST_GRANT, who, 1'b0);
                        end
                    end
                    else
                    begin
                        park_request(who, 1'b0);
                    end
                end
                CMD_EXIT_READ:
                begin
                    if (reader_count == 0)
                    begin
                        add_word(ST_ERROR, who, 1'b0);
                    end
                    else
                    begin
                        reader_count = reader_count - 1'b1;
                        if (reader_count == 0)
                            wake_waiters(grants);
                        if (grants == 0)
                            add_word(ST_RELEASED, who, 1'b0);
                    end
                end
                CMD_ENTER_WRITE:
                begin
                    if (!writer_busy && reader_count == 0)
                    begin
                        writer_busy = 1'b1;
                        add_word(ST_GRANT, who, 1'b1);
                    end
                    else
                    begin
                        park_request(who, 1'b1);
                    end
                end
                default:
                begin
                    if (!writer_busy)
                    begin
                        add_word(ST_ERROR, who, 1'b1);
                    end
                    else
                    begin
                        writer_busy = 1'b0;
                        wake_waiters(grants);
                        if (grants == 0)
                            add_word(ST_RELEASED, who, 1'b1);
                    end
                end
            endcase
        end
        // Mark the final word of this event
        w = expected_words.pop_back();
        w.last = 1'b1;
        expected_words.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            writer_busy  = 1'b0;
            reader_count = '0;
            wait_head    = 0;
            wait_tail    = 0;
            wait_count   = 0;
            expected_words.delete();
            failures     = 0;
            outstanding  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen_word.status = status;
                seen_word.who    = grant_requester;
                seen_word.kind   = grant_kind;
                seen_word.last   = last;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: extra word, want none, got st %0d who %0d kind %0d last %0d",
                             $time, seen_word.status, seen_word.who, seen_word.kind,
                             seen_word.last);
                    failures = failures + 1;
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (seen_word !== want_word)
                    begin
                        $display("%0t: mismatch, want st %0d who %0d kind %0d last %0d",
                                 $time, want_word.status, want_word.who, want_word.kind,
                                 want_word.last);
                        $display("%0t:           got st %0d who %0d kind %0d last %0d",
                                 $time, seen_word.status, seen_word.who, seen_word.kind,
                                 seen_word.last);
                        failures = failures + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_lock_event(command, requester);
            outstanding = expected_words.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the arbiter testbench: clock, reset, event stimulus and output back-pressure.
// Instantiates fifo_fair_readers_writers_arbiter_unit and frwa_lock_checker; uses frwa_pkg.
`timescale 1ns / 1ps

module testbench;
    import frwa_pkg::*;

    localparam int ITEMS_TARGET  = 310;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 200000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                out_stall;
    logic [CMD_W-1:0]    command;
    logic [REQ_W-1:0]    requester;
    wire                 in_stall;
    wire                 out_valid;
    wire [STATUS_W-1:0]  status;
    wire [REQ_W-1:0]     grant_requester;
    wire                 grant_kind;
    wire                 last;

    int failures;
    int outstanding;
    int words_sent;
    int burst_left;
    bit hold_off_req = 1'b0;

    fifo_fair_readers_writers_arbiter_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .requester       (requester),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .grant_requester (grant_requester),
        .grant_kind      (grant_kind),
        .last            (last)
    );

    frwa_lock_checker lock_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .requester       (requester),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .grant_requester (grant_requester),
        .grant_kind      (grant_kind),
        .last            (last),
        .failures        (failures),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Offer one word in bursts; stall is sampled at the falling edge so it is settled
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [REQ_W-1:0] who);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        in_valid  <= 1'b1;
        command   <= cmd;
        requester <= who;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        words_sent = words_sent + 1;
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic release_mix(input int n, input bit reads_only);
        repeat (n)
        begin
            if (!reads_only && $urandom_range(0, 2) == 0)
                send_word(CMD_EXIT_WRITE, REQ_W'($urandom_range(0, 15)));
            else
                send_word(CMD_EXIT_READ, REQ_W'($urandom_range(0, 15)));
        end
    endtask

    // Push the reader count toward its maximum, then release as many or up to four more
    task automatic read_flood();
        int n;
        n = $urandom_range(28, 34);
        repeat (n)
            send_word(CMD_ENTER_READ, REQ_W'($urandom_range(0, 15)));
        release_mix(n + $urandom_range(0, 4), 1'b1);
    endtask

    // Hold a writer while requests pile up behind it, then let the queue drain
    task automatic writer_backlog(input int k);
        send_word(CMD_ENTER_WRITE, REQ_W'($urandom_range(0, 15)));
        repeat (k)
        begin
            if ($urandom_range(0, 1) == 1)
                send_word(CMD_ENTER_WRITE, REQ_W'($urandom_range(0, 15)));
            else
                send_word(CMD_ENTER_READ, REQ_W'($urandom_range(0, 15)));
        end
        send_word(CMD_EXIT_WRITE, REQ_W'($urandom_range(0, 15)));
        release_mix(k + 2, 1'b0);
    endtask

    task automatic noise(input int n);
        repeat (n)
            send_word(CMD_W'($urandom_range(0, 3)), REQ_W'($urandom_range(0, 15)));
    endtask

    initial
    begin : receiver
        int span;
        int mode;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 40);
                repeat (span)
                begin
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= ($urandom_range(0, 1) == 1);
                        default: out_stall <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int pick;
        int seq_no;
        in_valid   = 1'b0;
        command    = '0;
        requester  = '0;
        rst_n      = 1'b0;
        words_sent = 0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unmatched exits on an idle lock
        send_word(CMD_EXIT_READ,   4'd0);
        send_word(CMD_EXIT_WRITE,  4'd15);
        // Two readers in, then a writer and more readers must wait
        send_word(CMD_ENTER_READ,  4'd1);
        send_word(CMD_ENTER_READ,  4'd14);
        send_word(CMD_ENTER_WRITE, 4'd2);
        send_word(CMD_ENTER_READ,  4'd3);
        send_word(CMD_ENTER_READ,  4'd4);
        send_word(CMD_ENTER_WRITE, 4'd5);
        // First exit grants nobody, the last reader hands off to the writer
        send_word(CMD_EXIT_READ,   4'd1);
        send_word(CMD_EXIT_READ,   4'd14);
        send_word(CMD_ENTER_WRITE, 4'd6);
        // Writer leaves: both readers at the head go together
        send_word(CMD_EXIT_WRITE,  4'd2);
        send_word(CMD_EXIT_READ,   4'd3);
        send_word(CMD_EXIT_READ,   4'd4);
        send_word(CMD_EXIT_WRITE,  4'd5);
        send_word(CMD_EXIT_WRITE,  4'd6);
        send_word(CMD_EXIT_WRITE,  4'd6);
        send_word(CMD_ENTER_READ,  4'd15);
        send_word(CMD_ENTER_WRITE, 4'd0);
        send_word(CMD_EXIT_READ,   4'd15);
        send_word(CMD_EXIT_WRITE,  4'd0);
        pause_until_drained();

        seq_no = 0;
        while (words_sent < ITEMS_TARGET)
        begin
            pick = (seq_no < 2) ? seq_no : $urandom_range(0, 9);
            if (seq_no == 3 || seq_no == 8)
                hold_off_req = 1'b1;
            if (seq_no == 5)
                pause_until_drained();
            if (pick == 0)
                read_flood();
            else if (pick < 7)
                writer_backlog((seq_no == 1) ? 18 : $urandom_range(1, 18));
            else
                noise($urandom_range(3, 10));
            seq_no = seq_no + 1;
        end

        in_valid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && outstanding != 0; i++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
